// ----- sv/sce_pkg.sv -----
`timescale 1ns / 1ps
package sce_pkg;

    localparam int CODE_LEN   = 6;
    localparam int DIGIT_CNT  = CODE_LEN - 1;
    localparam int HELD_W     = $clog2(CODE_LEN + 1);
    localparam int DIGIT_W    = 3;
    localparam int FIFO_DEPTH = 2;    // power of two, pointers wrap
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] PAD_CHAR   = 8'h30;
    localparam logic [7:0] CASE_DELTA = 8'h20;
    localparam logic [7:0] LOWER_A    = 8'h61;
    localparam logic [7:0] LOWER_Z    = 8'h7A;

    typedef struct packed {
        logic [7:0] char_in;
        logic       no_char;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [7:0] code_lead;
        logic [5:0] code_digit_1;
        logic [5:0] code_digit_2;
        logic [5:0] code_digit_3;
        logic [5:0] code_digit_4;
        logic [5:0] code_digit_5;
    } code_t;

    // Classified byte handed from front to back
    typedef struct packed {
        logic               has_byte;
        logic [7:0]         upper;
        logic [DIGIT_W-1:0] digit;
        logic               last;
    } cls_t;

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= LOWER_A && c <= LOWER_Z)
        begin
            r = c - CASE_DELTA;
        end
        return r;
    endfunction

    // Digit 1..6 for a letter, 0 when the byte is skipped
    function automatic logic [DIGIT_W-1:0] letter_digit(input logic [7:0] u);
        logic [DIGIT_W-1:0] d;
        case (u)
            "B", "F", "P", "V":                     d = 3'd1;
            "C", "G", "J", "K", "Q", "S", "X", "Z": d = 3'd2;
            "D", "T":                               d = 3'd3;
            "L":                                    d = 3'd4;
            "M", "N":                               d = 3'd5;
            "R":                                    d = 3'd6;
            default:                                d = 3'd0;
        endcase
        return d;
    endfunction

    function automatic logic [5:0] digit_char(input logic [DIGIT_W-1:0] d);
        return PAD_CHAR[5:0] | {3'b000, d};
    endfunction

endpackage

// ----- sv/sce_front.sv -----
`timescale 1ns / 1ps
module sce_front (
    input  logic          item_valid,
    output logic          item_stall,
    input  sce_pkg::item_t item,
    input  logic          fifo_full,
    output logic          push,
    output sce_pkg::cls_t  cls
);
    import sce_pkg::*;

    logic [7:0] upper;

    assign item_stall = fifo_full;
    assign push       = item_valid && !fifo_full;
    assign upper      = to_upper(item.char_in);

    always_comb
    begin
        cls.has_byte = !item.no_char && (item.char_in != 8'h00);
        cls.upper    = upper;
        cls.digit    = letter_digit(upper);
        cls.last     = item.last;
    end

endmodule

// ----- sv/sce_fifo.sv -----
`timescale 1ns / 1ps
module sce_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sce_pkg::cls_t  push_data,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output sce_pkg::cls_t  head
);
    import sce_pkg::*;

    cls_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] cnt_reg, cnt_next;

    assign full       = (cnt_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? FIFO_PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? FIFO_PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- sv/sce_back.sv -----
`timescale 1ns / 1ps
module sce_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  sce_pkg::cls_t  head,
    output logic          pop,
    output logic          code_valid,
    input  logic          code_stall,
    output sce_pkg::code_t code
);
    import sce_pkg::*;

    logic [7:0]         lead_reg, lead_next, lead_upd;
    logic [7:0]         prev_reg, prev_next, prev_upd;
    logic [HELD_W-1:0]  held_reg, held_next, held_upd;
    logic [DIGIT_W-1:0] digit_reg [DIGIT_CNT];
    logic [DIGIT_W-1:0] digit_next [DIGIT_CNT];
    logic [DIGIT_W-1:0] digit_upd [DIGIT_CNT];
    logic [7:0]         ch;
    logic               emit;
    logic               code_valid_reg, code_valid_next;
    code_t              code_reg, code_next;

    // A non-last item never needs the output register
    assign pop  = head_valid && (!head.last || !code_valid_reg || !code_stall);
    assign emit = pop && head.last;
    assign ch   = PAD_CHAR | {5'b00000, head.digit};

    always_comb
    begin
        lead_upd  = lead_reg;
        prev_upd  = prev_reg;
        held_upd  = held_reg;
        digit_upd = digit_reg;
        if (pop && head.has_byte)
        begin
            if (held_reg == '0)
            begin
                lead_upd = head.upper;
                prev_upd = head.upper;
                held_upd = HELD_W'(1);
            end
            else if (held_reg < HELD_W'(CODE_LEN) && head.digit != '0 && ch != prev_reg)
            begin
                for (int i = 0; i < DIGIT_CNT; i++)
                begin
                    if (held_reg == HELD_W'(i + 1))
                    begin
                        digit_upd[i] = head.digit;
                    end
                end
                prev_upd = ch;
                held_upd = held_reg + 1'b1;
            end
        end

        code_next.code_lead    = (held_upd == '0) ? PAD_CHAR : lead_upd;
        code_next.code_digit_1 = digit_char(digit_upd[0]);
        code_next.code_digit_2 = digit_char(digit_upd[1]);
        code_next.code_digit_3 = digit_char(digit_upd[2]);
        code_next.code_digit_4 = digit_char(digit_upd[3]);
        code_next.code_digit_5 = digit_char(digit_upd[4]);

        // End of string: start over
        if (emit)
        begin
            lead_next = '0;
            prev_next = '0;
            held_next = '0;
            for (int i = 0; i < DIGIT_CNT; i++)
            begin
                digit_next[i] = '0;
            end
        end
        else
        begin
            lead_next  = lead_upd;
            prev_next  = prev_upd;
            held_next  = held_upd;
            digit_next = digit_upd;
        end

        code_valid_next = code_valid_reg;
        if (emit)
        begin
            code_valid_next = 1'b1;
        end
        else if (!code_stall)
        begin
            code_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg       <= '0;
            prev_reg       <= '0;
            held_reg       <= '0;
            code_valid_reg <= 1'b0;
            for (int i = 0; i < DIGIT_CNT; i++)
            begin
                digit_reg[i] <= '0;
            end
        end
        else
        begin
            lead_reg       <= lead_next;
            prev_reg       <= prev_next;
            held_reg       <= held_next;
            code_valid_reg <= code_valid_next;
            digit_reg      <= digit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            code_reg <= code_next;
        end
    end

    assign code_valid = code_valid_reg;
    assign code       = code_reg;

endmodule

// ----- sv/soundex_code_encoder.sv -----
`timescale 1ns / 1ps
// Soundex code encoder.
// Input channel (item_valid / item_stall / item): one string byte per transfer,
// item.last closes the string, item.no_char marks a transfer with no byte
// (a zero byte counts the same). Output channel (code_valid / code_stall /
// code): one six-character code per string, on the transfer after its last item.
// Throughput: one input transfer per cycle while item_stall is low. The front
// classifies the byte (upper-case, digit lookup) into a two-entry queue; the back
// updates the code state, one queue entry per cycle unless a last entry waits
// on a held output, and registers the code and code_valid when it pops a last item.
// When code_stall holds the output, the back keeps taking non-last bytes;
// a last item waits at the queue head, and item_stall rises once the queue
// is full. Reset clears the code state, the queue and code_valid; no code
// is shown until a last item has been taken after reset.
module soundex_code_encoder (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_stall,
    input  sce_pkg::item_t  item,
    output logic           code_valid,
    input  logic           code_stall,
    output sce_pkg::code_t  code
);
    import sce_pkg::*;

    logic fifo_full;
    logic push;
    logic pop;
    logic head_valid;
    cls_t push_data;
    cls_t head;

    sce_front u_front (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .fifo_full  (fifo_full),
        .push       (push),
        .cls        (push_data)
    );

    sce_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    sce_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .code_valid (code_valid),
        .code_stall (code_stall),
        .code       (code)
    );

endmodule

// ----- sv/sce_checker.sv -----
`timescale 1ns / 1ps
module sce_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           item_valid,
    input logic           item_stall,
    input sce_pkg::item_t  item,
    input logic           code_valid,
    input logic           code_stall,
    input sce_pkg::code_t  code
);
    import sce_pkg::*;

    localparam logic [5:0] PAD6 = PAD_CHAR[5:0];
    localparam logic [5:0] MAX6 = PAD_CHAR[5:0] + 6'd6;

    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |=> item_valid && $stable(item))
        else $error("stalled item changed");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && code_stall |=> code_valid)
        else $error("code_valid dropped while stalled");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid |-> code.code_digit_1 >= PAD6 && code.code_digit_1 <= MAX6
                    && code.code_digit_2 >= PAD6 && code.code_digit_2 <= MAX6
                    && code.code_digit_3 >= PAD6 && code.code_digit_3 <= MAX6
                    && code.code_digit_4 >= PAD6 && code.code_digit_4 <= MAX6
                    && code.code_digit_5 >= PAD6 && code.code_digit_5 <= MAX6)
        else $error("code digit out of range");

    // Padding only trails: a '0' in the first digit means the rest are '0'
    a_pad_tail: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && code.code_digit_1 == PAD6 |->
            code.code_digit_2 == PAD6 && code.code_digit_3 == PAD6
            && code.code_digit_4 == PAD6 && code.code_digit_5 == PAD6)
        else $error("digit after padding");

    a_pad_tail_mid: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && code.code_digit_3 == PAD6 |->
            code.code_digit_4 == PAD6 && code.code_digit_5 == PAD6)
        else $error("digit after padding");

endmodule

bind soundex_code_encoder sce_checker u_sce_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .code_valid (code_valid),
    .code_stall (code_stall),
    .code       (code)
);

// ----- tb/tb_soundex_code_encoder.sv -----
`timescale 1ns / 1ps
module tb_soundex_code_encoder;
    import sce_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1600;
    localparam int QUIET_TAIL   = 150;
    localparam int DRAIN_CYCLES = 12;

    // Soundex digit per letter, A..Z, '0' = skipped
    localparam logic [8*26-1:0] LETTER_DIGITS = "01230120022455012623010202";

    typedef struct {
        item_t it;
        bit    hold;    // wait for every pending code before sending
    } feed_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  item_valid = 1'b0;
    logic  item_stall;
    item_t item = '0;
    logic  code_valid;
    logic  code_stall = 1'b0;
    code_t code;

    feed_t bytes_to_send[$];
    code_t codes_due[$];

    // predictor state
    logic [7:0] lead_q;
    logic [2:0] digits_q[0:4];
    int         held_q;
    logic [7:0] prev_q;

    int total_items;
    int items_sent;
    int codes_checked;
    int full_codes;
    int empty_codes;
    int errors;
    int cycles;
    int send_gap;
    int stall_left;
    int send_odds;
    int stall_odds;
    bit quiet;

    soundex_code_encoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .code_valid (code_valid),
        .code_stall (code_stall),
        .code       (code)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic void clear_code_state();
        lead_q = 8'h00;
        held_q = 0;
        prev_q = 8'h00;
        for (int i = 0; i < 5; i++)
        begin
            digits_q[i] = 3'd0;
        end
    endfunction

    // Fold one accepted transfer into the predicted code state
    function automatic void absorb_item(input item_t it);
        logic [7:0] up;
        logic [7:0] ch;
        logic [2:0] d;
        code_t      c;
        if (!it.no_char && it.char_in != 8'h00)
        begin
            up = it.char_in;
            if (up >= "a" && up <= "z")
            begin
                up = up - 8'h20;
            end
            if (held_q == 0)
            begin
                lead_q = up;
                prev_q = up;
                held_q = 1;
            end
            else if (held_q < CODE_LEN)
            begin
                d = 3'd0;
                if (up >= "A" && up <= "Z")
                begin
                    d = 3'(LETTER_DIGITS[8*(25 - int'(up - "A")) +: 8] - "0");
                end
                ch = 8'h30 + {5'd0, d};
                // lead counts as written, so a digit lead can block a digit
                if (d != 3'd0 && ch != prev_q)
                begin
                    digits_q[held_q - 1] = d;
                    prev_q = ch;
                    held_q++;
                end
            end
        end
        if (it.last)
        begin
            c.code_lead    = (held_q == 0) ? 8'h30 : lead_q;
            c.code_digit_1 = 6'h30 + {3'd0, digits_q[0]};
            c.code_digit_2 = 6'h30 + {3'd0, digits_q[1]};
            c.code_digit_3 = 6'h30 + {3'd0, digits_q[2]};
            c.code_digit_4 = 6'h30 + {3'd0, digits_q[3]};
            c.code_digit_5 = 6'h30 + {3'd0, digits_q[4]};
            if (held_q == CODE_LEN)
            begin
                full_codes++;
            end
            if (held_q == 0)
            begin
                empty_codes++;
            end
            codes_due.push_back(c);
            clear_code_state();
        end
    endfunction

    function automatic void queue_item(input logic [7:0] ch, input bit nc, input bit lst,
                                       input bit hold = 1'b0);
        feed_t f;
        f.it.char_in = ch;
        f.it.no_char = nc;
        f.it.last    = lst;
        f.hold       = hold;
        bytes_to_send.push_back(f);
    endfunction

    function automatic void queue_word(input string s, input bit close);
        for (int i = 0; i < s.len(); i++)
        begin
            queue_item(s[i], 1'b0, close && (i == s.len() - 1));
        end
    endfunction

    function automatic logic [7:0] pick_byte();
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6:
            begin
                b = 8'd65 + 8'($urandom_range(0, 25));
                if ($urandom_range(0, 1) == 1)
                begin
                    b = b + 8'h20;
                end
            end
            7:       b = 8'h30 + 8'($urandom_range(0, 9));
            8:       b = 8'($urandom_range(0, 255));
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic void queue_random_string();
        int  len;
        bit  hold;
        bit  nc_close;
        hold = ($urandom_range(0, 39) == 0);
        if ($urandom_range(0, 6) == 0)
        begin
            // noise: fully random transfers
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
            begin
                queue_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                           ($urandom_range(0, 3) == 0), hold && i == 0);
            end
            return;
        end
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 14) : $urandom_range(0, 6);
        if (len == 0)
        begin
            queue_item(8'($urandom_range(0, 255)), 1'b1, 1'b1, hold);
            return;
        end
        nc_close = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                queue_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, hold && i == 0);
                hold = 1'b0;
            end
            queue_item(pick_byte(), 1'b0, !nc_close && i == len - 1, hold && i == 0);
        end
        if (nc_close)
        begin
            queue_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
        end
    endfunction

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] got_v);
        if (exp_v !== got_v)
        begin
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
            errors++;
        end
    endtask

    // Sender: one transfer per accepted item, random gaps, drain pauses
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                absorb_item(item);
                items_sent++;
            end
            quiet = (total_items - items_sent) < QUIET_TAIL;
            if ($urandom_range(0, 199) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       send_odds = 0;
                    1:       send_odds = 3;
                    2:       send_odds = 8;
                    default: send_odds = 20;
                endcase
            end
            if (!item_valid || !item_stall)
            begin
                if (send_gap > 0)
                begin
                    item_valid <= 1'b0;
                    send_gap--;
                end
                else if (bytes_to_send.size() == 0)
                begin
                    item_valid <= 1'b0;
                end
                else if (bytes_to_send[0].hold && codes_due.size() != 0)
                begin
                    item_valid <= 1'b0;
                end
                else if (!quiet && send_odds != 0 && $urandom_range(1, send_odds) == 1)
                begin
                    item_valid <= 1'b0;
                    send_gap = $urandom_range(1, 13) - 1;
                end
                else
                begin
                    item       <= bytes_to_send[0].it;
                    item_valid <= 1'b1;
                    void'(bytes_to_send.pop_front());
                end
            end
        end
    end

    // Receiver: compare each code transfer, random stall bursts
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            code_stall <= 1'b0;
        end
        else
        begin
            if (code_valid && !code_stall)
            begin
                if (codes_due.size() == 0)
                begin
                    $display("%0t ns: unexpected code, expected none, got %h", $time, code);
                    errors++;
                end
                else
                begin
                    code_t want;
                    want = codes_due.pop_front();
                    check_field("code_lead", want.code_lead, code.code_lead);
                    check_field("code_digit_1", 8'(want.code_digit_1), 8'(code.code_digit_1));
                    check_field("code_digit_2", 8'(want.code_digit_2), 8'(code.code_digit_2));
                    check_field("code_digit_3", 8'(want.code_digit_3), 8'(code.code_digit_3));
                    check_field("code_digit_4", 8'(want.code_digit_4), 8'(code.code_digit_4));
                    check_field("code_digit_5", 8'(want.code_digit_5), 8'(code.code_digit_5));
                    codes_checked++;
                end
            end
            if ($urandom_range(0, 199) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       stall_odds = 0;
                    1:       stall_odds = 3;
                    2:       stall_odds = 8;
                    default: stall_odds = 20;
                endcase
            end
            if (stall_left > 0 && !quiet)
            begin
                code_stall <= 1'b1;
                stall_left--;
            end
            else if (!quiet && stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
            begin
                code_stall <= 1'b1;
                stall_left = $urandom_range(1, 13) - 1;
            end
            else
            begin
                code_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d codes still due", cycles, codes_due.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        clear_code_state();
        send_odds  = 8;
        stall_odds = 8;

        // empty string, zero byte alone, single bytes at the edges of the range
        queue_item(8'h5a, 1'b1, 1'b1);
        queue_item(8'h00, 1'b0, 1'b1);
        queue_item("z", 1'b0, 1'b1);
        queue_item(8'hff, 1'b0, 1'b1);
        queue_item(8'h80, 1'b0, 1'b1);
        // digit lead blocks the same digit right after it
        queue_word("1bd", 1'b1);
        // full code, then a byte past six characters, closed by a no-byte last
        queue_word("Rdlmnrxb", 1'b0);
        queue_item(8'h42, 1'b1, 1'b1);
        // no-byte item and zero byte inside a string; vowel between repeats
        queue_item("a", 1'b0, 1'b0);
        queue_item(8'hff, 1'b1, 1'b0);
        queue_item(8'h00, 1'b0, 1'b0);
        queue_word("kuQ", 1'b1);

        // random part starts with a full drain
        total_items = bytes_to_send.size() + 1;
        while (bytes_to_send.size() < total_items + RANDOM_ITEMS)
        begin
            queue_random_string();
            if (bytes_to_send.size() >= total_items)
            begin
                bytes_to_send[total_items - 1].hold = 1'b1;
            end
        end
        total_items = bytes_to_send.size();

        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (items_sent == total_items);
        wait (codes_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d input transfers, %0d codes checked (%0d full, %0d empty), %0d errors",
                 items_sent, codes_checked, full_codes, empty_codes, errors);
        $display("covered case folding, digit collapsing, skipped bytes and handshake stalls");
        if (errors == 0 && codes_due.size() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/sce_pkg.sv
sv/sce_front.sv
sv/sce_fifo.sv
sv/sce_back.sv
sv/soundex_code_encoder.sv
sv/sce_checker.sv
tb/tb_soundex_code_encoder.sv
